// File: hdl/rmt_pkg.sv
// Shared constants and types for the running median tracker.
`timescale 1ns / 1ps
`default_nettype none
package rmt_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = $clog2(CAPACITY_DEF + 1);

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP_INSERT
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    logic      flush;
  } chain_ctl_t;

endpackage
`default_nettype wire

// File: hdl/rmt_if.sv
// Valid/ready channel interfaces for samples in and medians out.
`timescale 1ns / 1ps
`default_nettype none
interface rmt_in_if #(
  parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface rmt_out_if #(
  parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = rmt_pkg::COUNT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_x2;
  logic [COUNT_BITS-1:0]       stored_count;
  logic                        dropped;

  modport source (output valid, output median_x2, output stored_count, output dropped,
                  input ready);
  modport sink (input valid, input median_x2, input stored_count, input dropped,
                output ready);
endinterface
`default_nettype wire

// File: hdl/rmt_cell.sv
// One cell of a sorted insertion chain: holds one sample and its occupancy bit.
`timescale 1ns / 1ps
`default_nettype none
module rmt_cell #(
  parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
  parameter bit DESC        = 1'b0,
  parameter bit HEAD        = 1'b0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  rmt_pkg::chain_ctl_t           ctl,
  input  wire signed [SAMPLE_BITS-1:0]  ins_val,
  input  wire signed [SAMPLE_BITS-1:0]  prev_val,
  input  wire                           prev_vld,
  input  wire                           prev_after,
  input  wire signed [SAMPLE_BITS-1:0]  next_val,
  input  wire                           next_after,
  output logic signed [SAMPLE_BITS-1:0] val_q,
  output logic                          vld_q,
  output logic                          after,
  output logic signed [SAMPLE_BITS-1:0] val_nxt
);

  logic signed [SAMPLE_BITS-1:0] val_r;
  logic                          vld_r;
  logic                          vld_nxt;
  logic                          vld_eff;
  logic signed [SAMPLE_BITS-1:0] tp_val;
  logic signed [SAMPLE_BITS-1:0] ts_val;
  logic                          tp_after;
  logic                          ts_after;

  // A cell is "after" the new value when the value belongs at or before it.
  always_comb begin
    vld_eff = vld_r & ~ctl.flush;
    if (DESC) begin
      after = ~vld_eff | (val_r < ins_val);
    end else begin
      after = ~vld_eff | (val_r > ins_val);
    end
  end

  always_comb begin
    tp_val   = prev_val;
    tp_after = prev_after;
    ts_val   = val_r;
    ts_after = after;
    vld_nxt  = vld_eff;
    val_nxt  = val_r;
    case (ctl.op)
      rmt_pkg::OP_INSERT: begin
        tp_val   = prev_val;
        tp_after = prev_after;
        ts_val   = val_r;
        ts_after = after;
        vld_nxt  = vld_eff | prev_vld;
        val_nxt  = tp_after ? tp_val : (ts_after ? ins_val : ts_val);
      end
      rmt_pkg::OP_POP_INSERT: begin
        tp_val   = val_r;
        tp_after = HEAD ? 1'b0 : after;
        ts_val   = next_val;
        ts_after = next_after;
        vld_nxt  = vld_eff;
        val_nxt  = tp_after ? tp_val : (ts_after ? ins_val : ts_val);
      end
      default: begin
        vld_nxt = vld_eff;
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;
  assign vld_q = vld_eff;

endmodule
`default_nettype wire

// File: hdl/rmt_chain.sv
// Row of cells that keeps one half of the samples sorted, best value at the head.
`timescale 1ns / 1ps
`default_nettype none
module rmt_chain #(
  parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH       = 128,
  parameter bit DESC        = 1'b0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  rmt_pkg::chain_ctl_t           ctl,
  input  wire signed [SAMPLE_BITS-1:0]  ins_val,
  output logic signed [SAMPLE_BITS-1:0] head,
  output logic signed [SAMPLE_BITS-1:0] head_nxt
);

  logic signed [SAMPLE_BITS-1:0] val_q   [DEPTH];
  logic signed [SAMPLE_BITS-1:0] val_nxt [DEPTH];
  logic                          vld_q   [DEPTH];
  logic                          after   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] p_val;
    logic                          p_vld;
    logic                          p_after;
    logic signed [SAMPLE_BITS-1:0] n_val;
    logic                          n_after;

    if (i == 0) begin : g_first
      assign p_val   = '0;
      assign p_vld   = 1'b1;
      assign p_after = 1'b0;
    end else begin : g_mid
      assign p_val   = val_q[i-1];
      assign p_vld   = vld_q[i-1];
      assign p_after = after[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_val   = '0;
      assign n_after = 1'b1;
    end else begin : g_inner
      assign n_val   = val_q[i+1];
      assign n_after = after[i+1];
    end

    rmt_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .DESC        (DESC),
      .HEAD        (i == 0)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .ins_val    (ins_val),
      .prev_val   (p_val),
      .prev_vld   (p_vld),
      .prev_after (p_after),
      .next_val   (n_val),
      .next_after (n_after),
      .val_q      (val_q[i]),
      .vld_q      (vld_q[i]),
      .after      (after[i]),
      .val_nxt    (val_nxt[i])
    );
  end

  assign head     = val_q[0];
  assign head_nxt = val_nxt[0];

endmodule
`default_nettype wire

// File: hdl/running_median_tracker_unit.sv
// Top level of the running median tracker.
`timescale 1ns / 1ps
`default_nettype none
// Each sample transfer inserts the sample into one of two sorted cell chains: the lower half
// of the set, kept largest first, and the upper half, kept smallest first, so the middle
// values always sit at the two chain heads. An insert, and a move of one head to the other
// chain to keep the halves balanced, happen in the same cycle, and the result (twice the
// median, the stored count and the drop flag) is registered on the clock edge of the transfer.
// The block takes one sample per cycle as long as results are taken; a result that waits
// holds off the next sample until it is transferred. Restart empties both chains at once.
module running_median_tracker_unit #(
  parameter int CAPACITY    = rmt_pkg::CAPACITY_DEF,
  parameter int SAMPLE_BITS = rmt_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = $clog2(CAPACITY + 1)
) (
  input  wire       clk,
  input  wire       rst_n,
  rmt_in_if.sink    in_chan,
  rmt_out_if.source out_chan
);

  localparam int LOW_DEPTH  = (CAPACITY + 1) / 2;
  localparam int HIGH_DEPTH = CAPACITY / 2;

  rmt_pkg::chain_ctl_t           low_ctl;
  rmt_pkg::chain_ctl_t           high_ctl;
  logic signed [SAMPLE_BITS-1:0] low_ins;
  logic signed [SAMPLE_BITS-1:0] high_ins;
  logic signed [SAMPLE_BITS-1:0] low_head;
  logic signed [SAMPLE_BITS-1:0] high_head;
  logic signed [SAMPLE_BITS-1:0] low_head_nxt;
  logic signed [SAMPLE_BITS-1:0] high_head_nxt;

  logic                          accept;
  logic                          full;
  logic [COUNT_BITS-1:0]         count_eff;
  logic [COUNT_BITS-1:0]         count_r;
  logic [COUNT_BITS-1:0]         count_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic signed [SAMPLE_BITS:0]   median_r;
  logic signed [SAMPLE_BITS:0]   median_nxt;
  logic [COUNT_BITS-1:0]         stored_r;
  logic                          dropped_r;

  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign accept        = in_chan.valid & in_chan.ready;

  always_comb begin
    count_eff = in_chan.restart ? '0 : count_r;
    full      = (count_eff == COUNT_BITS'(CAPACITY));
  end

  always_comb begin
    low_ctl.op     = rmt_pkg::OP_HOLD;
    high_ctl.op    = rmt_pkg::OP_HOLD;
    low_ctl.flush  = accept & in_chan.restart;
    high_ctl.flush = accept & in_chan.restart;
    low_ins        = in_chan.sample;
    high_ins       = in_chan.sample;
    if (accept && !full) begin
      if (!count_eff[0]) begin
        if (count_eff == '0 || in_chan.sample <= high_head) begin
          low_ctl.op = rmt_pkg::OP_INSERT;
        end else begin
          high_ctl.op = rmt_pkg::OP_POP_INSERT;
          low_ctl.op  = rmt_pkg::OP_INSERT;
          low_ins     = high_head;
        end
      end else begin
        if (in_chan.sample >= low_head) begin
          high_ctl.op = rmt_pkg::OP_INSERT;
        end else begin
          low_ctl.op  = rmt_pkg::OP_POP_INSERT;
          high_ctl.op = rmt_pkg::OP_INSERT;
          high_ins    = low_head;
        end
      end
    end
  end

  rmt_chain #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (LOW_DEPTH),
    .DESC        (1'b1)
  ) u_low (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (low_ctl),
    .ins_val  (low_ins),
    .head     (low_head),
    .head_nxt (low_head_nxt)
  );

  rmt_chain #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (HIGH_DEPTH),
    .DESC        (1'b0)
  ) u_high (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (high_ctl),
    .ins_val  (high_ins),
    .head     (high_head),
    .head_nxt (high_head_nxt)
  );

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = full ? count_eff : count_eff + COUNT_BITS'(1);
    end
    if (count_nxt[0]) begin
      median_nxt = {low_head_nxt, 1'b0};
    end else begin
      median_nxt = {low_head_nxt[SAMPLE_BITS-1], low_head_nxt}
                 + {high_head_nxt[SAMPLE_BITS-1], high_head_nxt};
    end
    out_valid_nxt = accept | (out_valid_r & ~out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median_r  <= median_nxt;
      stored_r  <= count_nxt;
      dropped_r <= full;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.median_x2    = median_r;
  assign out_chan.stored_count = stored_r;
  assign out_chan.dropped      = dropped_r;

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_chan.valid)
    else $error("No result after a sample transfer.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.stored_count != '0 &&
                        out_chan.stored_count <= COUNT_BITS'(CAPACITY)))
    else $error("Stored count out of range.");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.dropped) |-> out_chan.stored_count == COUNT_BITS'(CAPACITY))
    else $error("Sample dropped while the store was not full.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("Input held off with no result waiting.");
`endif

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the running median tracker.
`timescale 1ns / 1ps
module testbench;

  localparam int SB        = rmt_pkg::SAMPLE_BITS_DEF;
  localparam int CAP       = rmt_pkg::CAPACITY_DEF;
  localparam int CB        = $clog2(CAP + 1);
  localparam int IDLE_MAX  = 1000;
  localparam int HOLD_LEN  = 80;
  localparam int RAND_ITEMS = 750;

  typedef struct packed {
    logic signed [SB:0] median_x2;
    logic [CB-1:0]      stored_count;
    logic               dropped;
  } median_result_t;

  typedef struct {
    logic signed [SB-1:0] sample;
    logic                 restart;
    int                   reps;
    bit                   typed;
    median_result_t       want;
  } stim_row_t;

  // Rows marked typed carry a known answer; the others are checked by the predictor.
  stim_row_t directed_rows [15] = '{
    '{-32768, 1'b0, 1,   1'b1, '{-65536, 1, 0}},
    '{32767,  1'b0, 1,   1'b1, '{-1, 2, 0}},
    '{32767,  1'b0, 1,   1'b1, '{65534, 3, 0}},
    '{0,      1'b1, 1,   1'b1, '{0, 1, 0}},
    '{-1,     1'b0, 1,   1'b1, '{-1, 2, 0}},
    '{1,      1'b0, 1,   1'b1, '{0, 3, 0}},
    '{100,    1'b1, 1,   1'b1, '{200, 1, 0}},
    '{100,    1'b0, 3,   1'b0, '{0, 0, 0}},
    '{-3,     1'b0, 2,   1'b0, '{0, 0, 0}},
    '{-5,     1'b1, 1,   1'b1, '{-10, 1, 0}},
    '{7,      1'b0, 255, 1'b0, '{0, 0, 0}},
    '{-32768, 1'b0, 1,   1'b1, '{14, 256, 1}},
    '{32767,  1'b0, 1,   1'b1, '{14, 256, 1}},
    '{32767,  1'b1, 1,   1'b1, '{65534, 1, 0}},
    '{-32768, 1'b0, 1,   1'b1, '{-1, 2, 0}}
  };

  logic clk;
  logic rst_n;

  rmt_in_if  in_ch ();
  rmt_out_if out_ch ();

  running_median_tracker_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  logic signed [SB-1:0] tracked_sorted [CAP];
  int unsigned          tracked_count;
  median_result_t       pending_medians [$];
  bit                   row_typed;
  median_result_t       row_want;
  int                   burst_left;
  int                   hold_req_cnt;
  int                   err_count;
  int                   idle_cycles;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic median_result_t predict_median(input logic signed [SB-1:0] s,
                                                    input logic r);
    median_result_t res;
    int pos;
    int half;
    int lo;
    int hi;
    if (r) tracked_count = 0;
    res.dropped = (tracked_count >= CAP);
    if (!res.dropped) begin
      pos = tracked_count;
      while (pos > 0 && tracked_sorted[pos-1] > s) begin
        tracked_sorted[pos] = tracked_sorted[pos-1];
        pos--;
      end
      tracked_sorted[pos] = s;
      tracked_count++;
    end
    half = tracked_count / 2;
    hi = tracked_sorted[half];
    lo = tracked_count[0] ? hi : int'(tracked_sorted[half-1]);
    res.median_x2    = (SB+1)'(lo + hi);
    res.stored_count = CB'(tracked_count);
    return res;
  endfunction

  function automatic logic signed [SB-1:0] pick_sample(input int mode);
    case (mode)
      0:       return SB'($urandom);
      1:       return SB'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0:       return SB'(-32768);
          1:       return SB'(32767);
          2:       return SB'(-1);
          default: return SB'(0);
        endcase
      end
      default: return SB'(int'($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic offer_sample(input logic signed [SB-1:0] s, input logic r, input bit typed,
                              input median_result_t want);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= r;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    median_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = predict_median(in_ch.sample, in_ch.restart);
        pending_medians.push_back(row_typed ? row_want : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_medians.size() == 0) begin
          $error("result transfer with no median pending");
          err_count++;
        end else begin
          want = pending_medians.pop_front();
          if (out_ch.median_x2 !== want.median_x2) begin
            $error("median_x2: expected %0d, got %0d", want.median_x2, out_ch.median_x2);
            err_count++;
          end
          if (out_ch.stored_count !== want.stored_count) begin
            $error("stored_count: expected %0d, got %0d", want.stored_count,
                   out_ch.stored_count);
            err_count++;
          end
          if (out_ch.dropped !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, out_ch.dropped);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("[running_median_tracker_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_seen;
    int phase_len;
    int style;
    logic rdy;
    out_ch.ready = 1'b0;
    hold_left = 0;
    hold_seen = 0;
    phase_len = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_LEN;
      end
      if (phase_len == 0) begin
        style = $urandom_range(0, 2);
        phase_len = $urandom_range(16, 64);
      end
      phase_len--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (style)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  initial begin : stimulus
    int sent;
    int seq_idx;
    int run_len;
    int mode;
    bit long_run;
    logic r;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.restart = 1'b0;
    row_typed     = 1'b0;
    row_want      = '0;
    burst_left    = 0;
    hold_req_cnt  = 0;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        offer_sample(directed_rows[i].sample, directed_rows[i].restart, directed_rows[i].typed,
                     directed_rows[i].want);
      end
    end

    // Long runs start with a restart, fill the store and mostly keep going into drops; most short runs start with one.
    sent = 0;
    seq_idx = 0;
    while (sent < RAND_ITEMS) begin
      long_run = (seq_idx == 1 || seq_idx == 5);
      run_len = long_run ? $urandom_range(256, 280) : $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      if (seq_idx == 3) begin
        hold_req_cnt <= hold_req_cnt + 1;
      end
      if (seq_idx == 4) begin
        in_ch.valid <= 1'b0;
        wait (pending_medians.size() == 0);
        @(negedge clk);
      end
      for (int k = 0; k < run_len; k++) begin
        if (k == 0) begin
          r = long_run || ($urandom_range(0, 4) != 0);
        end else begin
          r = !long_run && ($urandom_range(0, 99) < 2);
        end
        offer_sample(pick_sample(mode), r, 1'b0, '0);
        sent++;
      end
      seq_idx++;
    end

    in_ch.valid <= 1'b0;
    wait (pending_medians.size() == 0);
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("[running_median_tracker_unit] OK");
    end else begin
      $display("[running_median_tracker_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rmt_pkg.sv
hdl/rmt_if.sv
hdl/rmt_cell.sv
hdl/rmt_chain.sv
hdl/running_median_tracker_unit.sv
tb/sv/testbench.sv
